// ----- hw/rtl/ccmm_pkg.sv -----
package ccmm_pkg;

  localparam int OP_W    = 2;
  localparam int VALUE_W = 10;
  localparam int CNT_W   = 10;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_SOLVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COIN,
    ST_TAB,
    ST_WRITE,
    ST_DONE
  } ccmm_state_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic load;
    logic res_zero;
    logic res_base;
    logic init;
    logic coin_step;
    logic acc_upd;
    logic wr_entry;
    logic res_acc;
    logic next_sum;
  } ccmm_cmd_t;

  typedef struct packed {
    logic big;
    logic tzero;
    logic czero;
    logic usable;
    logic last_coin;
    logic last_sum;
  } ccmm_sts_t;

endpackage

// ----- hw/rtl/ccmm_ram.sv -----
module ccmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ccmm_dp.sv -----
module ccmm_dp import ccmm_pkg::*; #(
  parameter int MAX_SUM   = 1024,
  parameter int MAX_COINS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [VALUE_W-1:0] in_coin_value,
  input  logic [VALUE_W-1:0] in_target_sum,
  input  ccmm_cmd_t          cmd,
  output ccmm_sts_t          sts,
  output logic               out_reachable,
  output logic [CNT_W-1:0]   out_fewest_coins,
  output logic [CNT_W-1:0]   out_most_coins
);

  localparam int TAW = (MAX_SUM > 1) ? $clog2(MAX_SUM) : 1;
  localparam int KW  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int CW  = $clog2(MAX_COINS + 1);
  localparam int EW  = 1 + 2 * CNT_W;

  logic [CW-1:0]      count_r, count_nxt;
  logic [VALUE_W-1:0] target_r, s_r;
  logic [KW-1:0]      k_r, k_nxt;
  logic               hit_r;
  logic [CNT_W-1:0]   lo_r, hi_r;
  logic               res_reach_r;
  logic [CNT_W-1:0]   res_min_r, res_max_r;

  logic               coin_we;
  logic [VALUE_W-1:0] coin_q;
  logic [VALUE_W-1:0] prev;
  logic               tab_we;
  logic [TAW-1:0]     tab_waddr, tab_raddr;
  logic [EW-1:0]      tab_wdata, tab_q;
  logic               t_reach;
  logic [CNT_W-1:0]   t_min, t_max, cmin, cmax;

  assign coin_we = cmd.add && (in_coin_value != '0) && (count_r < CW'(MAX_COINS));

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (coin_we) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // read address follows k_nxt so coin_q always matches k_r
  always_comb begin
    k_nxt = k_r;
    if (cmd.init || cmd.next_sum) begin
      k_nxt = '0;
    end else if (cmd.coin_step) begin
      k_nxt = k_r + KW'(1);
    end
  end

  ccmm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COINS)) u_coin_ram (
    .clk   (clk),
    .we    (coin_we),
    .waddr (count_r[KW-1:0]),
    .wdata (in_coin_value),
    .raddr (k_nxt),
    .rdata (coin_q)
  );

  assign prev      = s_r - coin_q;
  assign tab_raddr = TAW'(32'(prev));
  assign tab_we    = cmd.init || cmd.wr_entry;
  assign tab_waddr = cmd.init ? '0 : TAW'(32'(s_r));
  assign tab_wdata = cmd.init ? {1'b1, {CNT_W{1'b0}}, {CNT_W{1'b0}}} : {hit_r, lo_r, hi_r};

  ccmm_ram #(.WIDTH(EW), .DEPTH(MAX_SUM)) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_q)
  );

  assign t_reach = tab_q[EW-1];
  assign t_min   = tab_q[2*CNT_W-1:CNT_W];
  assign t_max   = tab_q[CNT_W-1:0];
  assign cmin    = t_min + CNT_W'(1);
  assign cmax    = t_max + CNT_W'(1);

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (cmd.load) begin
      target_r <= in_target_sum;
    end
    if (cmd.init) begin
      s_r <= VALUE_W'(1);
    end else if (cmd.next_sum) begin
      s_r <= s_r + VALUE_W'(1);
    end
    if (cmd.init || cmd.next_sum) begin
      hit_r <= 1'b0;
      lo_r  <= '0;
      hi_r  <= '0;
    end else if (cmd.acc_upd && t_reach) begin
      hit_r <= 1'b1;
      if (!hit_r || cmin < lo_r) begin
        lo_r <= cmin;
      end
      if (!hit_r || cmax > hi_r) begin
        hi_r <= cmax;
      end
    end
    if (cmd.res_zero) begin
      res_reach_r <= 1'b0;
      res_min_r   <= '0;
      res_max_r   <= '0;
    end else if (cmd.res_base) begin
      res_reach_r <= 1'b1;
      res_min_r   <= '0;
      res_max_r   <= '0;
    end else if (cmd.res_acc) begin
      res_reach_r <= hit_r;
      res_min_r   <= lo_r;
      res_max_r   <= hi_r;
    end
  end

  assign sts.big       = 32'(target_r) >= 32'(MAX_SUM);
  assign sts.tzero     = target_r == '0;
  assign sts.czero     = count_r == '0;
  assign sts.usable    = (coin_q != '0) && (coin_q <= s_r);
  assign sts.last_coin = (CW'(k_r) + CW'(1)) == count_r;
  assign sts.last_sum  = s_r == target_r;

  assign out_reachable    = res_reach_r;
  assign out_fewest_coins = res_min_r;
  assign out_most_coins   = res_max_r;

endmodule

// ----- hw/rtl/ccmm_ctrl.sv -----
module ccmm_ctrl import ccmm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] in_opcode,
  input  ccmm_sts_t       sts,
  output ccmm_cmd_t       cmd,
  output logic            busy,
  output logic            out_valid
);

  ccmm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_ADD:   cmd.add = 1'b1;
            OP_SOLVE: begin
              cmd.load  = 1'b1;
              state_nxt = ST_CHECK;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (sts.big) begin
          cmd.res_zero = 1'b1;
          state_nxt    = ST_DONE;
        end else if (sts.tzero) begin
          cmd.res_base = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = sts.czero ? ST_WRITE : ST_COIN;
        end
      end
      ST_COIN: begin
        // usable coin: table read at s - c is in flight
        if (sts.usable) begin
          state_nxt = ST_TAB;
        end else if (sts.last_coin) begin
          state_nxt = ST_WRITE;
        end else begin
          cmd.coin_step = 1'b1;
        end
      end
      ST_TAB: begin
        cmd.acc_upd = 1'b1;
        if (sts.last_coin) begin
          state_nxt = ST_WRITE;
        end else begin
          cmd.coin_step = 1'b1;
          state_nxt     = ST_COIN;
        end
      end
      ST_WRITE: begin
        cmd.wr_entry = 1'b1;
        if (sts.last_sum) begin
          cmd.res_acc = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.next_sum = 1'b1;
          state_nxt    = sts.czero ? ST_WRITE : ST_COIN;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = state_r == ST_DONE;

endmodule

// ----- hw/rtl/coin_change_min_max_counter_unit.sv -----
// Unbounded coin change: fewest and most coins that form a target sum.
// Request channel: start/busy with in_opcode, in_coin_value, in_target_sum.
// A request is taken on a clock edge with start high and busy low.
//   clear (opcode 0) and add (opcode 1) finish in the accepting cycle;
//   busy stays low and no result is produced. Opcode 3 is ignored.
//   solve (opcode 2) raises busy and produces exactly one result.
// Result channel: out_valid strobes for one cycle with out_reachable,
// out_fewest_coins and out_most_coins; the receiver cannot stall it.
// A solve answers a target of zero or at least MAX_SUM straight from
// the check state; otherwise its time grows with T, the target, n, the
// number of stored coins, and u, the coins no larger than the running sum.
// The cost comes from the table memory's one registered read port: each
// sum fetches every stored coin in turn and makes one lookup per usable coin.
// busy drops in the cycle after the strobe, so the next request is taken
// then. Reset empties the coin store and returns to idle; table memory is
// not cleared, since a solve writes each entry before reading it.
module coin_change_min_max_counter_unit import ccmm_pkg::*; #(
  parameter int MAX_SUM   = 1024,
  parameter int MAX_COINS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [VALUE_W-1:0] in_coin_value,
  input  logic [VALUE_W-1:0] in_target_sum,
  output logic               out_valid,
  output logic               out_reachable,
  output logic [CNT_W-1:0]   out_fewest_coins,
  output logic [CNT_W-1:0]   out_most_coins
);

  ccmm_cmd_t cmd;
  ccmm_sts_t sts;

  ccmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ccmm_dp #(.MAX_SUM(MAX_SUM), .MAX_COINS(MAX_COINS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_coin_value    (in_coin_value),
    .in_target_sum    (in_target_sum),
    .cmd              (cmd),
    .sts              (sts),
    .out_reachable    (out_reachable),
    .out_fewest_coins (out_fewest_coins),
    .out_most_coins   (out_most_coins)
  );

endmodule

// ----- hw/rtl/ccmm_chk.sv -----
module ccmm_chk import ccmm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [OP_W-1:0]    in_opcode,
  input logic               out_valid,
  input logic               out_reachable,
  input logic [CNT_W-1:0]   out_fewest_coins,
  input logic [CNT_W-1:0]   out_most_coins
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_SOLVE) |=> busy)
    else $error("solve request did not raise busy");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == OP_CLEAR || in_opcode == OP_ADD)) |=> !busy && !out_valid)
    else $error("store update made the unit busy");

  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reachable) |-> (out_fewest_coins == '0 && out_most_coins == '0))
    else $error("unreachable result with nonzero counts");

endmodule

bind coin_change_min_max_counter_unit ccmm_chk u_ccmm_chk (.*);

// ----- tb/sv/coin_change_min_max_counter_unit_tb.sv -----
module coin_change_min_max_counter_unit_tb;
  import ccmm_pkg::*;

  localparam int MAX_SUM      = 1024;
  localparam int MAX_COINS    = 16;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 50;

  // opcode 3 has no meaning in the block; it must be swallowed silently
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic             reachable;
    logic [CNT_W-1:0] fewest;
    logic [CNT_W-1:0] most;
  } coin_answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    in_opcode = OP_CLEAR;
  logic [VALUE_W-1:0] in_coin_value = '0;
  logic [VALUE_W-1:0] in_target_sum = '0;
  logic               out_valid;
  logic               out_reachable;
  logic [CNT_W-1:0]   out_fewest_coins;
  logic [CNT_W-1:0]   out_most_coins;

  // predictor state: denomination store and the three sum tables
  logic [VALUE_W-1:0] denoms [MAX_COINS];
  int                 denom_count = 0;
  bit                 reach_tab [MAX_SUM];
  logic [CNT_W-1:0]   fewest_tab [MAX_SUM];
  logic [CNT_W-1:0]   most_tab [MAX_SUM];

  coin_answer_t pending_answers[$];
  coin_answer_t oldest;

  int errors = 0;
  int burst_left = 0;
  int requests_accepted = 0;
  int results_checked = 0;
  int reachable_seen = 0;
  int cycle_count = 0;

  coin_change_min_max_counter_unit #(
    .MAX_SUM  (MAX_SUM),
    .MAX_COINS(MAX_COINS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_coin_value   (in_coin_value),
    .in_target_sum   (in_target_sum),
    .out_valid       (out_valid),
    .out_reachable   (out_reachable),
    .out_fewest_coins(out_fewest_coins),
    .out_most_coins  (out_most_coins)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Update the denomination store and, on a solve, queue the expected answer.
  function automatic void predict_coin_answer(input logic [OP_W-1:0] op,
                                              input logic [VALUE_W-1:0] coin,
                                              input logic [VALUE_W-1:0] target);
    coin_answer_t     ans;
    logic [CNT_W-1:0] lo, hi, cand_lo, cand_hi;
    logic             hit;
    int               s, k, prev;
    ans = '{1'b0, '0, '0};
    case (op)
      OP_CLEAR: denom_count = 0;
      OP_ADD: begin
        if (coin != 0 && denom_count < MAX_COINS) begin
          denoms[denom_count] = coin;
          denom_count++;
        end
      end
      OP_SOLVE: begin
        if (target < MAX_SUM) begin
          reach_tab[0] = 1'b1;
          fewest_tab[0] = '0;
          most_tab[0] = '0;
          for (s = 1; s <= target; s++) begin
            hit = 1'b0;
            lo = '0;
            hi = '0;
            for (k = 0; k < denom_count; k++) begin
              if (denoms[k] != 0 && denoms[k] <= s) begin
                prev = s - denoms[k];
                if (reach_tab[prev]) begin
                  cand_lo = fewest_tab[prev] + 1'b1;
                  cand_hi = most_tab[prev] + 1'b1;
                  if (!hit || cand_lo < lo) lo = cand_lo;
                  if (!hit || cand_hi > hi) hi = cand_hi;
                  hit = 1'b1;
                end
              end
            end
            reach_tab[s] = hit;
            fewest_tab[s] = lo;
            most_tab[s] = hi;
          end
          if (reach_tab[target]) ans = '{1'b1, fewest_tab[target], most_tab[target]};
        end
        pending_answers.push_back(ans);
      end
      default: ;
    endcase
  endfunction

  // Drive one request, idling in bursts, and hold it until the block takes it.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic [VALUE_W-1:0] coin,
                              input logic [VALUE_W-1:0] target);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_opcode <= op;
    in_coin_value <= coin;
    in_target_sum <= target;
    do @(posedge clk); while (busy);
    predict_coin_answer(op, coin, target);
    requests_accepted++;
  endtask

  task automatic test_empty_store();
    send_request(OP_SOLVE, 10'($urandom_range(0, 1023)), 10'd0);
    send_request(OP_SOLVE, 10'($urandom_range(0, 1023)), 10'd1023);
  endtask

  task automatic test_ignored_requests();
    send_request(OP_ADD, 10'd0, 10'($urandom_range(0, 1023)));
    send_request(OP_UNUSED, 10'd1, 10'd1);
    send_request(OP_SOLVE, 10'd0, 10'd1);
  endtask

  task automatic test_extreme_values();
    send_request(OP_ADD, 10'd1, 10'd0);
    send_request(OP_SOLVE, 10'd1023, 10'd1023);
    send_request(OP_ADD, 10'd1023, 10'd1023);
    send_request(OP_SOLVE, 10'd0, 10'd1023);
  endtask

  // Fill the store with large coins; the extra coin 1 must be dropped,
  // which leaves 1000 unreachable.
  task automatic test_store_full();
    int i;
    send_request(OP_CLEAR, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    for (i = 0; i < MAX_COINS; i++)
      send_request(OP_ADD, 10'(1023 - i), 10'($urandom_range(0, 1023)));
    send_request(OP_ADD, 10'd1, 10'($urandom_range(0, 1023)));
    send_request(OP_SOLVE, 10'($urandom_range(0, 1023)), 10'd1000);
  endtask

  task automatic test_random_sequences();
    int                 counted, solves, big_left, n_add, n_solve, i;
    logic [VALUE_W-1:0] value, goal;
    counted = 0;
    solves = 0;
    big_left = 4;
    while (counted < 70 || solves < 24) begin
      case ($urandom_range(0, 9))
        0: begin
          if ($urandom_range(0, 1))
            send_request(OP_UNUSED, 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)));
          else
            send_request(OP_ADD, '0, 10'($urandom_range(0, 1023)));
          counted++;
        end
        1: begin
          // extend the current store without clearing it
          send_request(OP_ADD, 10'($urandom_range(1, 60)), 10'($urandom_range(0, 1023)));
          send_request(OP_SOLVE, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 120)));
          counted += 2;
          solves++;
        end
        default: begin
          send_request(OP_CLEAR, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
          n_add = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 5);
          for (i = 0; i < n_add; i++) begin
            value = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(1, 1023))
                                                : 10'($urandom_range(1, 40));
            send_request(OP_ADD, value, 10'($urandom_range(0, 1023)));
          end
          n_solve = $urandom_range(1, 4);
          for (i = 0; i < n_solve; i++) begin
            // keep large targets rare: a solve costs cycles in proportion to the target
            if (big_left > 0 && $urandom_range(0, 19) == 0) begin
              goal = 10'($urandom_range(256, 1023));
              big_left--;
            end else begin
              goal = 10'($urandom_range(0, 160));
            end
            send_request(OP_SOLVE, 10'($urandom_range(0, 1023)), goal);
          end
          counted += 1 + n_add + n_solve;
          solves += n_solve;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with no request pending: reachable %0b fewest %0d most %0d",
                 $time, out_reachable, out_fewest_coins, out_most_coins);
        errors++;
      end else begin
        oldest = pending_answers.pop_front();
        results_checked++;
        if (out_reachable) reachable_seen++;
        if (out_reachable !== oldest.reachable) begin
          $display("%0t: reachable expected %0b actual %0b",
                   $time, oldest.reachable, out_reachable);
          errors++;
        end
        if (out_fewest_coins !== oldest.fewest) begin
          $display("%0t: fewest_coins expected %0d actual %0d",
                   $time, oldest.fewest, out_fewest_coins);
          errors++;
        end
        if (out_most_coins !== oldest.most) begin
          $display("%0t: most_coins expected %0d actual %0d",
                   $time, oldest.most, out_most_coins);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_answers.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_store();
    test_ignored_requests();
    test_extreme_values();
    test_store_full();
    test_random_sequences();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests (clear, add, solve, unused opcode) in %0d cycles.",
             requests_accepted, cycle_count);
    $display("Checked %0d solve results, %0d of them reachable; %0d errors.",
             results_checked, reachable_seen, errors);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ccmm_pkg.sv
hw/rtl/ccmm_ram.sv
hw/rtl/ccmm_dp.sv
hw/rtl/ccmm_ctrl.sv
hw/rtl/coin_change_min_max_counter_unit.sv
hw/rtl/ccmm_chk.sv
tb/sv/coin_change_min_max_counter_unit_tb.sv
